[src/rrts_pkg.sv]
`timescale 1ns / 1ps
// Round-robin task scheduler: shared types and constants.
// No dependencies; used by every module of the scheduler.
package rrts_pkg;

	localparam int NUM_TASKS  = 5;
	localparam int TICK_WIDTH = 32;
	localparam int TASK_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic FUNC_TICK = 1'b0;

	typedef struct packed {
		logic        func;
		logic [31:0] delay_ticks;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  running_task;
		logic [4:0]  ready_mask;
		logic [31:0] tick_now;
	} out_item_t;

	// classified event as held in the queue
	typedef struct packed {
		logic                  is_tick;
		logic [TICK_WIDTH-1:0] delay;
	} cmd_t;

endpackage

[src/rrts_front.sv]
`timescale 1ns / 1ps
// Front end: accepts event transactions, classifies them, queues them.
// Depends on rrts_pkg.
module rrts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rrts_pkg::in_item_t req,
	output logic              cmd_valid,
	output rrts_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);
	import rrts_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	cmd_t              cls;

	assign req_stall = (count_q == QCNT_W'(QDEPTH));
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_comb begin
		cls.is_tick = (req.func == FUNC_TICK);
		cls.delay   = TICK_WIDTH'(req.delay_ticks);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/rrts_back.sv]
`timescale 1ns / 1ps
// Back end: applies tick/delay events to the task state, picks the next
// task round robin and holds the result transaction. Depends on rrts_pkg.
module rrts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  rrts_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rrts_pkg::out_item_t rsp
);
	import rrts_pkg::*;

	localparam logic ST_UPD = 1'b0;
	localparam logic ST_SEL = 1'b1;

	logic                  state_q;
	logic [TICK_WIDTH-1:0] tick_q;
	logic [TASK_W-1:0]     running_q;
	logic [NUM_TASKS-1:0]  ready_q;
	logic [TICK_WIDTH-1:0] wake_q [NUM_TASKS];
	logic                  sel_pend_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [TICK_WIDTH-1:0] tick_inc;
	logic [NUM_TASKS-1:0]  wake_hit;
	logic                  do_upd;
	logic                  do_sel;
	logic [TASK_W-1:0]     chosen;
	logic [TASK_W-1:0]     next_run;
	logic [TASK_W:0]       sum;

	assign tick_inc  = tick_q + 1'b1;
	assign do_upd    = (state_q == ST_UPD) && cmd_valid;
	assign cmd_pop   = do_upd;
	assign do_sel    = (state_q == ST_SEL) && (!out_valid_q || !rsp_stall);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		wake_hit = '0;
		for (int i = 1; i < NUM_TASKS; i++) begin
			wake_hit[i] = !ready_q[i] && (wake_q[i] == tick_inc);
		end
	end

	// lowest rotation offset wins, so scan from the far end
	always_comb begin
		chosen = '0;
		sum    = '0;
		for (int n = NUM_TASKS; n >= 1; n--) begin
			sum = {1'b0, running_q} + (TASK_W + 1)'(n);
			if (sum >= (TASK_W + 1)'(NUM_TASKS)) begin
				sum = sum - (TASK_W + 1)'(NUM_TASKS);
			end
			if (sum[TASK_W-1:0] != '0 && ready_q[sum[TASK_W-1:0]]) begin
				chosen = sum[TASK_W-1:0];
			end
		end
		next_run = sel_pend_q ? chosen : running_q;
	end

	always_ff @(posedge clk) begin
		if (do_upd && !cmd.is_tick && running_q != '0) begin
			wake_q[running_q] <= tick_q + cmd.delay;
		end
		if (do_sel) begin
			out_q.running_task <= 3'(next_run);
			out_q.ready_mask   <= 5'(ready_q);
			out_q.tick_now     <= 32'(tick_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_UPD;
			tick_q      <= '0;
			running_q   <= TASK_W'(1);
			ready_q     <= '1;
			sel_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_UPD: begin
					if (do_upd) begin
						state_q <= ST_SEL;
						if (cmd.is_tick) begin
							tick_q     <= tick_inc;
							ready_q    <= ready_q | wake_hit;
							sel_pend_q <= 1'b1;
						end else if (running_q != '0) begin
							ready_q[running_q] <= 1'b0;
							sel_pend_q         <= 1'b1;
						end else begin
							sel_pend_q <= 1'b0;
						end
					end
				end
				ST_SEL: begin
					if (do_sel) begin
						running_q <= next_run;
						state_q   <= ST_UPD;
					end
				end
				default: state_q <= ST_UPD;
			endcase

			if (do_sel) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/round_robin_task_scheduler_unit.sv]
`timescale 1ns / 1ps
// Round-robin task scheduler, top level.
// Depends on rrts_pkg, rrts_front and rrts_back.
//
// Usage: each req transaction is one event: a timer tick (func 0) or a delay
// request from the running task (func 1, delay_ticks). Every event gives
// exactly one rsp transaction with the task chosen to run, the ready mask and
// the tick counter after the event. Task 0 is the idle task.
// Both channels: a transaction moves at a clock edge with valid high and
// stall low.
// A request seen by an idle block is registered in the queue, applied in the
// back end's state update step, then selected into the output register on rsp.
// The back end handles one event at a time in two steps (state update, then
// round-robin selection) and pops the next event only after its selection.
// A two-entry queue sits between front and back; req_stall rises when it is
// full. While rsp_stall is high the held result stays put, the back end waits
// in its selection step, and the queue keeps taking events until full.
// Reset (arst_n low) clears the queue and output, sets the tick counter to 0,
// marks every task ready and makes task 1 the running task.
module round_robin_task_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rrts_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rrts_pkg::out_item_t rsp
);
	import rrts_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	rrts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rrts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[verif/round_robin_task_scheduler_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_task_scheduler_unit: random tick and delay traffic
// with bursty input, patterned output stalls and one long hold-off; results checked in order.
// Depends on rrts_pkg and round_robin_task_scheduler_unit.
module round_robin_task_scheduler_unit_tb;

	import rrts_pkg::*;

	localparam logic FUNC_DELAY = ~FUNC_TICK;
	localparam int   IDLE_LIMIT = 4000;
	localparam int   RANDOM_EVENTS = 2000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	in_item_t  pending_events[$];
	out_item_t expected_sched[$];

	// scheduler state as predicted
	logic [31:0]          sched_tick;
	logic [2:0]           sched_run;
	logic [NUM_TASKS-1:0] sched_ready;
	logic [31:0]          sched_wake [NUM_TASKS];

	int fail_count = 0;
	int rsp_count = 0;
	int idle_cycles = 0;

	round_robin_task_scheduler_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	function automatic out_item_t next_schedule(input in_item_t ev);
		out_item_t  r;
		int         i;
		int         n;
		int         idx;
		logic [2:0] pick;
		bit         reselect;
		reselect = 1'b0;
		if (ev.func == FUNC_TICK) begin
			sched_tick = sched_tick + 32'd1;
			for (i = 1; i < NUM_TASKS; i++)
				if (!sched_ready[i] && sched_wake[i] == sched_tick)
					sched_ready[i] = 1'b1;
			reselect = 1'b1;
		end else if (sched_run != 3'd0) begin
			sched_wake[sched_run] = sched_tick + ev.delay_ticks;
			sched_ready[sched_run] = 1'b0;
			reselect = 1'b1;
		end
		if (reselect) begin
			idx = sched_run;
			pick = 3'd0;
			for (n = 0; n < NUM_TASKS; n++) begin
				idx = (idx + 1) % NUM_TASKS;
				if (idx != 0 && sched_ready[idx] && pick == 3'd0)
					pick = idx[2:0];
			end
			sched_run = pick;
		end
		r.running_task = sched_run;
		r.ready_mask   = sched_ready;
		r.tick_now     = sched_tick;
		return r;
	endfunction

	task automatic add_event(input logic f, input logic [31:0] d);
		in_item_t ev;
		ev.func = f;
		ev.delay_ticks = d;
		pending_events.push_back(ev);
	endtask

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk) begin : driver
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			req_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!req_valid || !req_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				req <= pending_events.pop_front();
				req_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern changes per segment, one long hold-off
	always @(posedge clk) begin : receiver
		int  hold_left;
		int  seg_left;
		int  stall_mode;
		bit  held_once;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
			seg_left = 0;
			stall_mode = 0;
			held_once = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (!held_once && rsp_count >= 500) begin
			held_once = 1'b1;
			hold_left = 300;
			rsp_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 60);
				stall_mode = $urandom_range(0, 3);
			end else begin
				seg_left--;
			end
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	// monitor: check results, then predict for accepted events
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_count <= rsp_count + 1;
				if (expected_sched.size() == 0) begin
					note_failure($sformatf("unexpected transaction task=%0d mask=%b tick=%0d",
						rsp.running_task, rsp.ready_mask, rsp.tick_now));
				end else begin
					want = expected_sched.pop_front();
					if (rsp.running_task != want.running_task ||
					    rsp.ready_mask != want.ready_mask ||
					    rsp.tick_now != want.tick_now)
						note_failure($sformatf(
							"exp task=%0d mask=%b tick=%0d, got task=%0d mask=%b tick=%0d",
							want.running_task, want.ready_mask, want.tick_now,
							rsp.running_task, rsp.ready_mask, rsp.tick_now));
				end
			end
			if (req_valid && !req_stall)
				expected_sched.push_back(next_schedule(req));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** round_robin_task_scheduler_unit: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		sched_tick = '0;
		sched_run = 3'd1;
		sched_ready = '1;
		for (i = 0; i < NUM_TASKS; i++)
			sched_wake[i] = '0;

		// directed: block every task, delay from idle, simultaneous wake-ups
		add_event(FUNC_TICK, 32'hFFFF_FFFF);
		add_event(FUNC_TICK, 32'h0000_0000);
		add_event(FUNC_DELAY, 32'd3);
		add_event(FUNC_DELAY, 32'd3);
		add_event(FUNC_DELAY, 32'd4);
		add_event(FUNC_DELAY, 32'd4);
		add_event(FUNC_DELAY, 32'd9);
		add_event(FUNC_DELAY, 32'h8000_0000);
		add_event(FUNC_TICK, 32'h5555_5555);
		add_event(FUNC_TICK, 32'hAAAA_AAAA);
		add_event(FUNC_TICK, 32'd0);
		add_event(FUNC_TICK, 32'd0);
		add_event(FUNC_DELAY, 32'd1);
		add_event(FUNC_TICK, 32'd0);
		add_event(FUNC_TICK, 32'd0);
		add_event(FUNC_TICK, 32'd0);
		add_event(FUNC_DELAY, 32'd2);
		add_event(FUNC_DELAY, 32'd2);
		add_event(FUNC_TICK, 32'd0);
		add_event(FUNC_TICK, 32'd0);

		// short delays keep tasks cycling; tick payloads are random noise
		for (i = 0; i < RANDOM_EVENTS; i++) begin
			if ($urandom_range(0, 9) < 4)
				add_event(FUNC_DELAY, ($urandom_range(0, 9) < 8) ?
					$urandom_range(1, 12) : $urandom_range(13, 150));
			else
				add_event(FUNC_TICK, $urandom);
		end

		// zero and huge delays block for a full counter wrap, so they come last
		add_event(FUNC_DELAY, 32'd0);
		add_event(FUNC_TICK, $urandom);
		add_event(FUNC_DELAY, 32'hFFFF_FFFF);
		add_event(FUNC_TICK, $urandom);
		add_event(FUNC_DELAY, $urandom | 32'h8000_0000);
		add_event(FUNC_TICK, $urandom);
		add_event(FUNC_DELAY, $urandom);
		for (i = 0; i < 4; i++)
			add_event(FUNC_TICK, $urandom);
		add_event(FUNC_DELAY, 32'd5);
		add_event(FUNC_TICK, $urandom);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() > 0 || req_valid)
			@(negedge clk);
		while (expected_sched.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_count == 0)
			$display("** round_robin_task_scheduler_unit: PASSED **");
		else
			$display("** round_robin_task_scheduler_unit: FAILED **");
		$finish;
	end

endmodule
